>>> hdl/iira_pkg.sv
// Package for the indexed insert/remove array: op and status codes, beat types.
package iira_pkg;

	localparam logic [2:0] OP_INS_AT    = 3'd0;
	localparam logic [2:0] OP_INS_FRONT = 3'd1;
	localparam logic [2:0] OP_INS_BACK  = 3'd2;
	localparam logic [2:0] OP_REM_AT    = 3'd3;
	localparam logic [2:0] OP_REM_FRONT = 3'd4;
	localparam logic [2:0] OP_REM_BACK  = 3'd5;
	localparam logic [2:0] OP_READ      = 3'd6;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	typedef struct packed {
		logic [2:0]         op;
		logic [6:0]         position;
		logic signed [31:0] value;
	} iira_in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] read_value;
		logic [6:0]         length;
	} iira_out_t;

endpackage

>>> hdl/iira_ram.sv
// Entry store: one write port, one read port, registered read data.
module iira_ram import iira_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic signed [31:0] wdata,
	input  logic [AW-1:0]      raddr,
	output logic signed [31:0] rdata
);

	logic signed [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/indexed_insert_remove_array.sv
// Top level of the indexed insert/remove array: op sequencer around the entry store.
//
//  channel  | ports              | handshake
//  ---------+--------------------+-------------------------------------------
//  command  | start, busy, cmd   | beat taken at clk edge with start & !busy
//  result   | done, rsp          | one-cycle strobe, receiver cannot stall
//
// Per beat: a read passes through one read state; an error, an unused op or a
// removal of the last entry ends without leaving idle. A grow past the end
// writes one entry per cycle: zeros up to the new last entry, which takes the value.
// A shift up or down moves one entry per cycle through the single read and write
// port of the store; the longest beat is a shift of CAPACITY - 1 entries.
// Reset clears the length and the sequencer; the store itself is not cleared,
// since no entry below the length is ever read before it was written.
// busy is high while a multi-cycle op runs; the result strobe never waits.
module indexed_insert_remove_array import iira_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  iira_in_t  cmd,
	output logic      busy,
	output logic      done,
	output iira_out_t rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	// internal position width: holds a 7-bit position or the length, plus one
	localparam int PW = ((CW > 7) ? CW : 7) + 1;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_READ = 5'b00010,
		S_FILL = 5'b00100,
		S_UP   = 5'b01000,
		S_DN   = 5'b10000
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      ptr_q;    // next store address to read (or write in fill)
	logic [AW-1:0]      stop_q;   // last address of the sweep
	logic [AW-1:0]      wa_q;     // write target for data coming back from the store
	logic               rd_go_q;  // sweep still issuing reads
	logic               pend_q;   // read data arrives this cycle
	logic signed [31:0] val_q;
	logic [1:0]         stat_q;
	logic signed [31:0] rdv_q;
	logic               done_q;

	// store ports
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic signed [31:0] ram_wdata;
	logic [AW-1:0]      ram_raddr;
	logic signed [31:0] ram_rdata;

	// command decode
	logic          accept;
	logic [PW-1:0] pos_ext;
	logic [PW-1:0] cnt_ext;
	logic [PW-1:0] ins_pos;
	logic [PW-1:0] rem_pos;
	logic          ins_grow;
	logic          ins_full;
	logic          rem_empty;
	logic          rem_bad;
	logic          rem_last;
	logic          rd_bad;

	iira_ram #(
		.DEPTH(CAPACITY),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign accept  = start && !busy;
	assign pos_ext = PW'(cmd.position);
	assign cnt_ext = PW'(count_q);

	always_comb begin
		case (cmd.op)
			OP_INS_FRONT: ins_pos = '0;
			OP_INS_BACK:  ins_pos = cnt_ext;
			default:      ins_pos = pos_ext;
		endcase
		case (cmd.op)
			OP_REM_FRONT: rem_pos = '0;
			OP_REM_BACK:  rem_pos = cnt_ext - PW'(1);
			default:      rem_pos = pos_ext;
		endcase
	end

	// insert at or past the end grows to position+1; inside, it grows by one
	assign ins_grow  = ins_pos >= cnt_ext;
	assign ins_full  = ins_grow ? (ins_pos + PW'(1) > PW'(CAPACITY))
	                            : (cnt_ext + PW'(1) > PW'(CAPACITY));
	assign rem_empty = (cmd.op == OP_REM_FRONT || cmd.op == OP_REM_BACK) && count_q == '0;
	assign rem_bad   = rem_pos >= cnt_ext;
	assign rem_last  = rem_pos + PW'(1) == cnt_ext;
	assign rd_bad    = pos_ext >= cnt_ext;

	// store access per state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				// read issued on every cycle; used only by the read op
				ram_raddr = AW'(cmd.position);
			end
			S_READ: begin
				ram_raddr = '0;
			end
			S_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q;
				ram_wdata = (ptr_q == stop_q) ? val_q : '0;
			end
			S_UP: begin
				ram_raddr = ptr_q;
				if (pend_q) begin
					ram_we    = 1'b1;
					ram_waddr = wa_q;
					ram_wdata = ram_rdata;
				end else if (!rd_go_q) begin
					// shift drained: drop the new value into the hole
					ram_we    = 1'b1;
					ram_waddr = stop_q;
					ram_wdata = val_q;
				end
			end
			S_DN: begin
				ram_raddr = ptr_q;
				if (pend_q) begin
					ram_we    = 1'b1;
					ram_waddr = wa_q;
					ram_wdata = ram_rdata;
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ptr_q   <= '0;
			stop_q  <= '0;
			wa_q    <= '0;
			rd_go_q <= 1'b0;
			pend_q  <= 1'b0;
			val_q   <= '0;
			stat_q  <= ST_OK;
			rdv_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						stat_q  <= ST_OK;
						rdv_q   <= '0;
						val_q   <= cmd.value;
						rd_go_q <= 1'b1;
						pend_q  <= 1'b0;
						unique case (cmd.op)
							OP_INS_AT, OP_INS_FRONT, OP_INS_BACK: begin
								if (ins_full) begin
									stat_q <= ST_FULL;
									done_q <= 1'b1;
								end else if (ins_grow) begin
									ptr_q   <= AW'(cnt_ext);
									stop_q  <= AW'(ins_pos);
									count_q <= CW'(ins_pos + PW'(1));
									state_q <= S_FILL;
								end else begin
									ptr_q   <= AW'(cnt_ext - PW'(1));
									stop_q  <= AW'(ins_pos);
									count_q <= count_q + CW'(1);
									state_q <= S_UP;
								end
							end
							OP_REM_AT, OP_REM_FRONT, OP_REM_BACK: begin
								if (rem_empty) begin
									stat_q <= ST_EMPTY;
									done_q <= 1'b1;
								end else if (rem_bad) begin
									stat_q <= ST_RANGE;
									done_q <= 1'b1;
								end else begin
									count_q <= count_q - CW'(1);
									if (rem_last) begin
										done_q <= 1'b1;
									end else begin
										ptr_q   <= AW'(rem_pos + PW'(1));
										stop_q  <= AW'(cnt_ext - PW'(1));
										state_q <= S_DN;
									end
								end
							end
							OP_READ: begin
								if (rd_bad) begin
									stat_q <= ST_RANGE;
									done_q <= 1'b1;
								end else begin
									state_q <= S_READ;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_READ: begin
					rdv_q   <= ram_rdata;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_FILL: begin
					ptr_q <= ptr_q + AW'(1);
					if (ptr_q == stop_q) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_UP: begin
					// read entry i, write it to i+1 next cycle; walk downward
					pend_q <= rd_go_q;
					if (rd_go_q) begin
						wa_q <= ptr_q + AW'(1);
						if (ptr_q == stop_q) begin
							rd_go_q <= 1'b0;
						end else begin
							ptr_q <= ptr_q - AW'(1);
						end
					end else if (!pend_q) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_DN: begin
					// read entry i, write it to i-1 next cycle; walk upward
					pend_q <= rd_go_q;
					if (rd_go_q) begin
						wa_q <= ptr_q - AW'(1);
						if (ptr_q == stop_q) begin
							rd_go_q <= 1'b0;
						end else begin
							ptr_q <= ptr_q + AW'(1);
						end
					end else if (!pend_q) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy            = state_q != S_IDLE;
	assign done            = done_q;
	assign rsp.status      = stat_q;
	assign rsp.read_value  = rdv_q;
	assign rsp.length      = 7'(count_q);

	// length never passes the capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("length above capacity");

	// the store is only written by a running op
	a_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> busy)
		else $error("store written while idle");

	// a result follows an accepted command or a running op
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(start) || $past(busy)))
		else $error("result without a command");

	// an error result leaves the length as it was
	a_err_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ST_OK) |-> count_q == $past(count_q))
		else $error("error changed the length");

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the indexed insert/remove array: directed and random list edits.
`timescale 1ns / 1ps

module testbench;
	import iira_pkg::*;

	localparam int CAPACITY       = 64;
	localparam int N_RANDOM       = 800;
	// No beat is taken and no result comes for this many cycles: the run is stuck.
	// The limit lies well above the slowest beat plus the longest sender gap.
	localparam int WATCHDOG_LIMIT = 1000;
	// Cycles to wait after the last result in case the block emits something stray.
	localparam int SETTLE_CYCLES  = 2 * CAPACITY;
	localparam int MAX_PRINTED    = 40;

	// Op code 7 has no name in the package; the block treats it as a no-op.
	localparam logic [2:0] OP_UNUSED = 3'd7;

	// One command beat waiting to go out, with its lead-in gap.
	// hold: do not send until every outstanding result has come back.
	typedef struct packed {
		iira_in_t   c;
		logic [3:0] gap;
		logic       hold;
	} pending_t;

	// A command that was taken and the result it must produce.
	typedef struct packed {
		iira_in_t  c;
		iira_out_t r;
	} op_outcome_t;

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      start  = 1'b0;
	iira_in_t  cmd    = '0;
	logic      busy;
	logic      done;
	iira_out_t rsp;

	indexed_insert_remove_array #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done),
		.rsp   (rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// List predictor: its own copy of the entries and the length.
	// The generator runs it once over the whole stimulus to steer positions
	// and op mix, then it is cleared and replayed beat by beat as the block
	// takes commands.
	// ------------------------------------------------------------------
	logic signed [31:0] list_ent [CAPACITY];
	int                 list_len;

	// Insert inside the list shifts up; at or past the end zero-fills the gap.
	function automatic logic [1:0] list_insert(input int pos, input logic signed [31:0] val);
		int i;
		if (pos >= list_len) begin
			if (pos + 1 > CAPACITY)
				return ST_FULL;
			for (i = list_len; i < pos; i++)
				list_ent[i] = '0;
			list_ent[pos] = val;
			list_len      = pos + 1;
		end else begin
			if (list_len + 1 > CAPACITY)
				return ST_FULL;
			for (i = list_len; i > pos; i--)
				list_ent[i] = list_ent[i - 1];
			list_ent[pos] = val;
			list_len      = list_len + 1;
		end
		return ST_OK;
	endfunction

	function automatic logic [1:0] list_remove(input int pos);
		int i;
		if (pos >= list_len)
			return ST_RANGE;
		for (i = pos; i + 1 < list_len; i++)
			list_ent[i] = list_ent[i + 1];
		list_len = list_len - 1;
		return ST_OK;
	endfunction

	// Applies one command to the predicted list and returns the result beat.
	// Errors leave the list alone; read_value is zero except on a good read.
	function automatic iira_out_t apply_list_op(input iira_in_t c);
		iira_out_t r;
		r.status     = ST_OK;
		r.read_value = '0;
		case (c.op)
			OP_INS_AT:    r.status = list_insert(c.position, c.value);
			OP_INS_FRONT: r.status = list_insert(0, c.value);
			OP_INS_BACK:  r.status = list_insert(list_len, c.value);
			OP_REM_AT:    r.status = list_remove(c.position);
			OP_REM_FRONT: begin
				if (list_len == 0)
					r.status = ST_EMPTY;
				else
					r.status = list_remove(0);
			end
			OP_REM_BACK: begin
				if (list_len == 0)
					r.status = ST_EMPTY;
				else
					r.status = list_remove(list_len - 1);
			end
			OP_READ: begin
				if (c.position < list_len)
					r.read_value = list_ent[c.position];
				else
					r.status = ST_RANGE;
			end
			default: ;  // unused op: nothing changes
		endcase
		r.length = list_len[6:0];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus generation
	// ------------------------------------------------------------------
	pending_t    cmd_q[$];      // command beats not yet handed to the driver
	op_outcome_t outcome_q[$];  // results owed by the block, oldest first
	logic        burst   = 1'b0;  // no sender gaps while set
	logic        growing = 1'b1;  // op mix leans toward inserts while set

	task automatic queue_cmd(input logic [2:0] op, input int pos,
	                         input logic signed [31:0] val, input logic hold);
		pending_t  p;
		p.c.op       = op;
		p.c.position = pos[6:0];
		p.c.value    = val;
		p.gap        = burst ? 4'd0 : 4'($urandom_range(0, 8));
		p.hold       = hold;
		void'(apply_list_op(p.c));
		cmd_q.push_back(p);
	endtask

	// Mostly inside the list or right at its end, some just past it, some anywhere.
	function automatic int pick_position();
		int r;
		int hi;
		r  = $urandom_range(0, 99);
		hi = (list_len + 8 > 127) ? 127 : list_len + 8;
		if (r < 70)
			return $urandom_range(0, list_len);
		if (r < 85)
			return $urandom_range(list_len, hi);
		return $urandom_range(0, 127);
	endfunction

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 19))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return '0;
			3:       return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Driver: command beats change on the falling edge. cmd_taken is set by
	// the monitor at the rising edge that took the beat. A start that stays
	// high for back-to-back beats gets one assignment per edge.
	// ------------------------------------------------------------------
	pending_t next_cmd;
	logic     have_next = 1'b0;
	logic     cmd_taken = 1'b0;
	int       gap_left  = 0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (cmd_taken || !start) begin
				cmd_taken = 1'b0;
				if (!have_next && cmd_q.size() != 0) begin
					next_cmd  = cmd_q.pop_front();
					gap_left  = next_cmd.gap;
					have_next = 1'b1;
				end
				if (have_next && gap_left == 0 && !(next_cmd.hold && outcome_q.size() != 0)) begin
					start     <= 1'b1;
					cmd       <= next_cmd.c;
					have_next = 1'b0;
				end else begin
					if (have_next && gap_left != 0)
						gap_left--;
					start <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: results are checked at the rising edge that ends their strobe
	// cycle; a taken command beat is predicted at the edge that takes it.
	// ------------------------------------------------------------------
	int          n_errors    = 0;
	int          n_cmds      = 0;
	int          n_results   = 0;
	int          peak_len    = 0;
	int          idle_cycles = 0;
	int          status_seen [4] = '{0, 0, 0, 0};
	op_outcome_t owed;
	op_outcome_t taken;

	task automatic report_mismatch(input string msg);
		n_errors++;
		if (n_errors <= MAX_PRINTED)
			$display("MISMATCH at %0t ns: %s", $time, msg);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				n_results++;
				status_seen[rsp.status]++;
				if (outcome_q.size() == 0) begin
					report_mismatch($sformatf("result beat with nothing outstanding (status %0d)",
						rsp.status));
				end else begin
					owed = outcome_q.pop_front();
					if (rsp.status !== owed.r.status)
						report_mismatch($sformatf("op %0d pos %0d: status %0d, want %0d",
							owed.c.op, owed.c.position, rsp.status, owed.r.status));
					if (rsp.read_value !== owed.r.read_value)
						report_mismatch($sformatf("op %0d pos %0d: read_value %0d, want %0d",
							owed.c.op, owed.c.position, rsp.read_value, owed.r.read_value));
					if (rsp.length !== owed.r.length)
						report_mismatch($sformatf("op %0d pos %0d: length %0d, want %0d",
							owed.c.op, owed.c.position, rsp.length, owed.r.length));
				end
			end
			if (start && !busy) begin
				taken.c = cmd;
				taken.r = apply_list_op(cmd);
				outcome_q.push_back(taken);
				cmd_taken = 1'b1;
				n_cmds++;
				if (list_len > peak_len)
					peak_len = list_len;
			end
			if (done || (start && !busy))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
					idle_cycles, outcome_q.size());
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence: build the whole stimulus in zero time, reset, then wait for
	// the driver to run dry and every result to come back.
	// ------------------------------------------------------------------
	initial begin
		int         k;
		int         r;
		int         ins_share;
		logic [2:0] op;

		list_len = 0;

		// Empty list: front/back removal reports empty, positional ops report range.
		queue_cmd(OP_REM_FRONT, 0, 32'sd5, 1'b0);
		queue_cmd(OP_REM_BACK, 127, 32'sd5, 1'b0);
		queue_cmd(OP_REM_AT, 0, 32'sd0, 1'b0);
		queue_cmd(OP_READ, 0, 32'sd0, 1'b0);
		queue_cmd(OP_UNUSED, 127, -32'sd1, 1'b0);
		// Build a short list with extreme values, an inside insert and a gap fill.
		queue_cmd(OP_INS_BACK, 0, 32'sh7fff_ffff, 1'b0);
		queue_cmd(OP_INS_FRONT, 127, 32'sh8000_0000, 1'b0);
		queue_cmd(OP_INS_AT, 1, -32'sd1, 1'b0);
		queue_cmd(OP_INS_AT, 5, 32'sh1234_5678, 1'b0);
		queue_cmd(OP_READ, 4, 32'sd0, 1'b0);
		queue_cmd(OP_READ, 5, 32'sd0, 1'b0);
		// Reads at and far past the end.
		queue_cmd(OP_READ, 6, 32'sd0, 1'b0);
		queue_cmd(OP_READ, 127, 32'sd0, 1'b0);
		// Try to grow beyond capacity (refused), then fill to exactly capacity in one beat.
		queue_cmd(OP_INS_AT, 127, 32'sd9, 1'b0);
		queue_cmd(OP_INS_AT, CAPACITY - 1, 32'sd1, 1'b0);
		// Full list: every kind of insert is refused.
		queue_cmd(OP_INS_BACK, 0, 32'sd2, 1'b0);
		queue_cmd(OP_INS_FRONT, 0, 32'sd3, 1'b0);
		queue_cmd(OP_INS_AT, 10, 32'sd4, 1'b0);
		queue_cmd(OP_READ, CAPACITY - 1, 32'sd0, 1'b0);
		// Removal at bad positions, then every kind of good removal.
		queue_cmd(OP_REM_AT, CAPACITY, 32'sd0, 1'b0);
		queue_cmd(OP_REM_AT, 127, 32'sd0, 1'b0);
		queue_cmd(OP_REM_AT, 0, 32'sd0, 1'b0);
		queue_cmd(OP_REM_BACK, 0, 32'sd0, 1'b0);
		queue_cmd(OP_REM_FRONT, 0, 32'sd0, 1'b0);
		queue_cmd(OP_UNUSED, 0, 32'sd0, 1'b0);
		queue_cmd(OP_REM_AT, 30, 32'sd0, 1'b0);

		// Random part. The first beat, and a few more, wait for the block to
		// drain completely before going out.
		for (k = 0; k < N_RANDOM; k++) begin
			if ($urandom_range(0, 39) == 0)
				burst = !burst;
			if (list_len >= CAPACITY - 4)
				growing = 1'b0;
			else if (list_len <= 2)
				growing = 1'b1;
			else if ($urandom_range(0, 49) == 0)
				growing = !growing;
			ins_share = growing ? 60 : 30;
			r = $urandom_range(0, 99);
			if (r < 2)
				op = OP_UNUSED;
			else if (r < 15)
				op = OP_READ;
			else if (r < 15 + ins_share) begin
				case ($urandom_range(0, 2))
					0:       op = OP_INS_AT;
					1:       op = OP_INS_FRONT;
					default: op = OP_INS_BACK;
				endcase
			end else begin
				case ($urandom_range(0, 2))
					0:       op = OP_REM_AT;
					1:       op = OP_REM_FRONT;
					default: op = OP_REM_BACK;
				endcase
			end
			queue_cmd(op, pick_position(), pick_value(),
				(k == 0) || ($urandom_range(0, 59) == 0));
		end

		// Replay starts from an empty list, as the block does out of reset.
		list_len = 0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (cmd_q.size() != 0 || have_next || start)
			@(posedge clk);
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (outcome_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", outcome_q.size()));

		$display("covered: %0d command beats, %0d result beats, list length up to %0d",
			n_cmds, n_results, peak_len);
		$display("statuses seen: ok %0d, bad position %0d, empty %0d, full %0d; %0d mismatches",
			status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_EMPTY],
			status_seen[ST_FULL], n_errors);
		if (n_errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
